// ===== hw/rtl/tga_pkg.sv =====
// tga_pkg: shared types and constants for the targa stream decoder
// parser phases, header byte offsets, result and divider structs
// no dependencies
package tga_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PACKET,
    PH_PIXEL,
    PH_IGNORE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ERR_COLORMAP  = 3'd2;
  localparam logic [2:0] ERR_BAD_BPP   = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;
  localparam logic [2:0] ERR_EMPTY     = 3'd5;

  localparam logic [7:0] IMG_RGB  = 8'd2;
  localparam logic [7:0] IMG_GRAY = 8'd3;
  localparam logic [7:0] IMG_RLE  = 8'd10;

  localparam logic [7:0] BPP_8  = 8'd8;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  localparam logic [2:0] PIX_BYTES_GRAY = 3'd1;
  localparam logic [2:0] PIX_BYTES_RGBA = 3'd4;

  localparam logic [4:0] HDR_ID_LEN = 5'd0;
  localparam logic [4:0] HDR_CMAP   = 5'd1;
  localparam logic [4:0] HDR_TYPE   = 5'd2;
  localparam logic [4:0] HDR_W_LO   = 5'd12;
  localparam logic [4:0] HDR_W_HI   = 5'd13;
  localparam logic [4:0] HDR_H_LO   = 5'd14;
  localparam logic [4:0] HDR_H_HI   = 5'd15;
  localparam logic [4:0] HDR_BPP    = 5'd16;
  localparam logic [4:0] HDR_DESC   = 5'd17;

  localparam int ATTR_TOP_BIT = 5;
  localparam int PKT_RUN_BIT  = 7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam int DIV_STEPS = 4;
  localparam int TDATA_W   = 112;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [15:0] dest_row;
    logic [15:0] dest_column;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  error_code;
    logic        image_done;
  } res_t;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic [16:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  quo;
    logic [15:0] rem;
  } div_res_t;

endpackage

// ===== hw/rtl/tga_div.sv =====
// tga_div: small iterative divider for run repositioning
// eight quotient bits, four per cycle; done pulses once the last quotient bit is in
// depends on tga_pkg
module tga_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tga_pkg::div_req_t req,
  output tga_pkg::div_res_t res
);
  import tga_pkg::*;

  logic        busy_r, busy_nxt;
  logic        step_r, step_nxt;
  logic        done_r, done_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  dvd_r, dvd_nxt;
  logic [7:0]  quo_r, quo_nxt;

  always_comb begin
    logic [16:0] trial;
    logic [15:0] r;
    logic [7:0]  d;
    logic [7:0]  q;
    r        = rem_r;
    d        = dvd_r;
    q        = quo_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = busy_r && step_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r, d[7]};
      d     = {d[6:0], 1'b0};
      if (trial >= {1'b0, req.divisor}) begin
        r = 16'(trial - {1'b0, req.divisor});
        q = {q[6:0], 1'b1};
      end else begin
        r = trial[15:0];
        q = {q[6:0], 1'b0};
      end
    end
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    if (req.clear) begin
      busy_nxt = 1'b0;
      step_nxt = 1'b0;
      done_nxt = 1'b0;
    end else if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 1'b0;
      rem_nxt  = {7'd0, req.dividend[16:8]};
      dvd_nxt  = req.dividend[7:0];
      quo_nxt  = 8'd0;
    end else if (busy_r) begin
      rem_nxt  = r;
      dvd_nxt  = d;
      quo_nxt  = q;
      step_nxt = ~step_r;
      if (step_r) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

// ===== hw/rtl/tga_parse.sv =====
// tga_parse: byte-wise header parser, packet decoder and pixel placement
// one accepted byte updates the parse state and may produce one result
// depends on tga_pkg and tga_div
module tga_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    data_byte,
  input  logic          stream_end,
  output logic          res_valid,
  output tga_pkg::res_t res
);
  import tga_pkg::*;

  phase_t      phase_r, phase_nxt, phase_adv;
  logic [4:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  img_kind_r, img_kind_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic        cmap_r, cmap_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [7:0]  bpp_r, bpp_nxt;
  logic        top_r, top_nxt;
  logic [31:0] color_r, color_nxt;
  logic [1:0]  pbi_r, pbi_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_run_r, pkt_run_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic [31:0] pix_left_r, pix_left_nxt;

  div_req_t    div_req;
  div_res_t    div_res;

  logic [2:0]  pix_bytes;
  logic [31:0] acc_new;
  logic        last_byte;
  logic        is_rle;
  logic [7:0]  run_cnt;
  logic [7:0]  cnt;
  logic        img_done;
  logic [7:0]  pkt_next;
  logic [2:0]  hdr_code;
  logic        bpp_ok;
  phase_t      data_phase;
  logic [31:0] pix_total;
  logic [16:0] col_inc;

  tga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign pix_bytes  = bpp_r[5:3];
  assign acc_new    = color_r | ({24'd0, data_byte} << {pbi_r, 3'b000});
  assign last_byte  = ({1'b0, pbi_r} + 3'd1) >= pix_bytes;
  assign is_rle     = img_kind_r == IMG_RLE;
  assign run_cnt    = (pix_left_r < {24'd0, pkt_left_r}) ? pix_left_r[7:0] : pkt_left_r;
  assign cnt        = (is_rle && pkt_run_r) ? run_cnt : 8'd1;
  assign img_done   = {24'd0, cnt} == pix_left_r;
  assign pkt_next   = !is_rle ? pkt_left_r : (pkt_run_r ? 8'd0 : 8'(pkt_left_r - 8'd1));
  assign data_phase = is_rle ? PH_PACKET : PH_PIXEL;
  assign pix_total  = {16'd0, width_r} * {16'd0, height_r};
  assign col_inc    = {1'b0, col_r} + 17'd1;

  assign bpp_ok = (bpp_r == BPP_24) || (bpp_r == BPP_32) ||
                  (bpp_r == BPP_8 && img_kind_r == IMG_GRAY);

  always_comb begin
    if (img_kind_r != IMG_RGB && img_kind_r != IMG_GRAY && img_kind_r != IMG_RLE) begin
      hdr_code = ERR_BAD_TYPE;
    end else if (cmap_r) begin
      hdr_code = ERR_COLORMAP;
    end else if (!bpp_ok) begin
      hdr_code = ERR_BAD_BPP;
    end else if (width_r == 16'd0 || height_r == 16'd0) begin
      hdr_code = ERR_EMPTY;
    end else begin
      hdr_code = ERR_NONE;
    end
  end

  // next phase
  always_comb begin
    phase_adv = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r == HDR_DESC) begin
            if (hdr_code != ERR_NONE) begin
              phase_adv = PH_IGNORE;
            end else if (id_left_r != 8'd0) begin
              phase_adv = PH_IDSKIP;
            end else begin
              phase_adv = data_phase;
            end
          end
        end
        PH_IDSKIP: begin
          if (id_left_r == 8'd1) begin
            phase_adv = data_phase;
          end
        end
        PH_PACKET: phase_adv = PH_PIXEL;
        PH_PIXEL: begin
          if (last_byte) begin
            if (img_done) begin
              phase_adv = PH_IGNORE;
            end else if (is_rle && pkt_next == 8'd0) begin
              phase_adv = PH_PACKET;
            end
          end
        end
        PH_IGNORE: phase_adv = PH_IGNORE;
        default:   phase_adv = PH_HEADER;
      endcase
    end
    phase_nxt = (in_fire && stream_end) ? PH_HEADER : phase_adv;
  end

  // datapath and result
  always_comb begin
    hdr_idx_nxt  = hdr_idx_r;
    img_kind_nxt = img_kind_r;
    id_left_nxt  = id_left_r;
    cmap_nxt     = cmap_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    bpp_nxt      = bpp_r;
    top_nxt      = top_r;
    color_nxt    = color_r;
    pbi_nxt      = pbi_r;
    pkt_left_nxt = pkt_left_r;
    pkt_run_nxt  = pkt_run_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pix_left_nxt = pix_left_r;
    res_valid    = 1'b0;
    res          = '0;
    div_req.start    = 1'b0;
    div_req.clear    = 1'b0;
    div_req.dividend = {1'b0, col_r} + {9'd0, cnt};
    div_req.divisor  = width_r;

    if (div_res.done) begin
      col_nxt = div_res.rem;
      row_nxt = top_r ? 16'(row_r + {8'd0, div_res.quo}) : 16'(row_r - {8'd0, div_res.quo});
    end

    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          unique case (hdr_idx_r)
            HDR_ID_LEN: id_left_nxt = data_byte;
            HDR_CMAP:   cmap_nxt = data_byte != 8'd0;
            HDR_TYPE:   img_kind_nxt = data_byte;
            HDR_W_LO:   width_nxt[7:0] = data_byte;
            HDR_W_HI:   width_nxt[15:8] = data_byte;
            HDR_H_LO:   height_nxt[7:0] = data_byte;
            HDR_H_HI:   height_nxt[15:8] = data_byte;
            HDR_BPP: begin
              bpp_nxt      = data_byte;
              pix_left_nxt = pix_total;
            end
            HDR_DESC: begin
              top_nxt          = data_byte[ATTR_TOP_BIT];
              res_valid        = 1'b1;
              res.image_width  = width_r;
              res.image_height = height_r;
              if (hdr_code != ERR_NONE) begin
                res.kind       = KIND_ERROR;
                res.error_code = hdr_code;
              end else begin
                res.kind = KIND_HEADER;
                row_nxt  = data_byte[ATTR_TOP_BIT] ? 16'd0 : 16'(height_r - 16'd1);
                col_nxt  = 16'd0;
              end
            end
            default: ;
          endcase
          if (hdr_idx_r != HDR_DESC) begin
            hdr_idx_nxt = 5'(hdr_idx_r + 5'd1);
          end
        end
        PH_IDSKIP: id_left_nxt = 8'(id_left_r - 8'd1);
        PH_PACKET: begin
          pkt_left_nxt = {1'b0, data_byte[6:0]} + 8'd1;
          pkt_run_nxt  = data_byte[PKT_RUN_BIT];
          color_nxt    = 32'd0;
          pbi_nxt      = 2'd0;
        end
        PH_PIXEL: begin
          if (!last_byte) begin
            color_nxt = acc_new;
            pbi_nxt   = 2'(pbi_r + 2'd1);
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_PIXEL;
            res.blue         = acc_new[7:0];
            res.green        = (pix_bytes == PIX_BYTES_GRAY) ? acc_new[7:0] : acc_new[15:8];
            res.red          = (pix_bytes == PIX_BYTES_GRAY) ? acc_new[7:0] : acc_new[23:16];
            res.alpha        = (pix_bytes == PIX_BYTES_RGBA) ? acc_new[31:24] : ALPHA_OPAQUE;
            res.repeat_count = cnt;
            res.dest_row     = row_r;
            res.dest_column  = col_r;
            res.image_width  = width_r;
            res.image_height = height_r;
            res.image_done   = img_done;
            color_nxt        = 32'd0;
            pbi_nxt          = 2'd0;
            pkt_left_nxt     = pkt_next;
            pix_left_nxt     = pix_left_r - {24'd0, cnt};
            if (cnt == 8'd1) begin
              if (col_inc == {1'b0, width_r}) begin
                col_nxt = 16'd0;
                row_nxt = top_r ? 16'(row_r + 16'd1) : 16'(row_r - 16'd1);
              end else begin
                col_nxt = col_inc[15:0];
              end
            end else begin
              div_req.start = 1'b1;
            end
          end
        end
        PH_IGNORE: ;
        default: ;
      endcase

      if (stream_end) begin
        if (phase_adv != PH_IGNORE) begin
          res_valid        = 1'b1;
          res              = '0;
          res.kind         = KIND_ERROR;
          res.error_code   = ERR_TRUNCATED;
          res.image_width  = width_nxt;
          res.image_height = height_nxt;
        end
        hdr_idx_nxt   = 5'd0;
        img_kind_nxt  = 8'd0;
        id_left_nxt   = 8'd0;
        cmap_nxt      = 1'b0;
        width_nxt     = 16'd0;
        height_nxt    = 16'd0;
        bpp_nxt       = 8'd0;
        top_nxt       = 1'b0;
        color_nxt     = 32'd0;
        pbi_nxt       = 2'd0;
        pkt_left_nxt  = 8'd0;
        pkt_run_nxt   = 1'b0;
        row_nxt       = 16'd0;
        col_nxt       = 16'd0;
        pix_left_nxt  = 32'd0;
        div_req.start = 1'b0;
        div_req.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= 5'd0;
      img_kind_r <= 8'd0;
      id_left_r  <= 8'd0;
      cmap_r     <= 1'b0;
      width_r    <= 16'd0;
      height_r   <= 16'd0;
      bpp_r      <= 8'd0;
      top_r      <= 1'b0;
      color_r    <= 32'd0;
      pbi_r      <= 2'd0;
      pkt_left_r <= 8'd0;
      pkt_run_r  <= 1'b0;
      row_r      <= 16'd0;
      col_r      <= 16'd0;
      pix_left_r <= 32'd0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      img_kind_r <= img_kind_nxt;
      id_left_r  <= id_left_nxt;
      cmap_r     <= cmap_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      bpp_r      <= bpp_nxt;
      top_r      <= top_nxt;
      color_r    <= color_nxt;
      pbi_r      <= pbi_nxt;
      pkt_left_r <= pkt_left_nxt;
      pkt_run_r  <= pkt_run_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      pix_left_r <= pix_left_nxt;
    end
  end

endmodule

// ===== hw/rtl/tga_image_decoder.sv =====
// tga_image_decoder: top level of the targa stream decoder
// byte input stream, registered result stream; depends on tga_pkg and tga_parse
//
// Feed the bytes of one targa file, one item per byte, with tlast on the final
// byte; the decoder then clears itself for the next file. It takes one byte
// every clock and answers with at most one result item per byte, registered in
// a single output register; a byte is taken whenever that register is empty or
// being drained, so throughput is one byte per cycle unless the sink stalls.
// A run packet is repositioned by a divider that works in the background,
// hidden behind the packet and color bytes that must follow it. Results:
// tuser 0 is a pixel run, 1 header accepted, 2 error report; tlast marks the
// run that completes the image.
module tga_image_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_tdata,   // data_byte
  input  logic                         in_tlast,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // red, green, blue, alpha, repeat_count, dest_row, dest_column,
  // image_width, image_height, error_code, zero fill
  output logic [tga_pkg::TDATA_W-1:0]  out_tdata,
  output logic [1:0]                   out_tuser,  // kind
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready
);
  import tga_pkg::*;

  logic  in_fire;
  logic  res_valid;
  res_t  res;
  res_t  out_r, out_nxt;
  logic  out_valid_r, out_valid_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  tga_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_tdata),
    .stream_end (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (in_fire && res_valid) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.image_done;
  assign out_tdata  = {5'd0, out_r.error_code, out_r.image_height, out_r.image_width,
                       out_r.dest_column, out_r.dest_row, out_r.repeat_count,
                       out_r.alpha, out_r.blue, out_r.green, out_r.red};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for tga_image_decoder, one targa file byte per item
// a scoreboard class predicts each header, pixel run and error result; needs tga_pkg
module tb;
  import tga_pkg::*;

  class decode_tracker;
    res_t expected_results[$];
    int errors;
    phase_t phase;
    logic [4:0] hdr_idx;
    logic [7:0] img_type, id_left, depth;
    logic [15:0] width, height, row, col, rows_left;
    logic top, cmap;
    logic [31:0] acc;
    logic [1:0] byte_idx;
    logic [7:0] pkt_left;
    logic pkt_run;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_HEADER;
      hdr_idx = '0;
      img_type = '0;
      id_left = '0;
      depth = '0;
      width = '0;
      height = '0;
      row = '0;
      col = '0;
      rows_left = '0;
      top = 1'b0;
      cmap = 1'b0;
      acc = '0;
      byte_idx = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
    endfunction

    function phase_t data_phase();
      return (img_type == IMG_RLE) ? PH_PACKET : PH_PIXEL;
    endfunction

    function res_t error_result(logic [2:0] code);
      res_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.image_width = width;
      r.image_height = height;
      r.error_code = code;
      return r;
    endfunction

    // emits a run at the current position and advances; 1 when the image is full
    function bit pixel_run(int unsigned count, output res_t r);
      int unsigned nbytes, total, adv;
      bit done;
      nbytes = 32'(depth >> 3);
      r = '0;
      r.kind = KIND_PIXEL;
      r.blue = acc[7:0];
      if (nbytes == PIX_BYTES_GRAY) begin
        r.green = acc[7:0];
        r.red = acc[7:0];
      end else begin
        r.green = acc[15:8];
        r.red = acc[23:16];
      end
      r.alpha = (nbytes == PIX_BYTES_RGBA) ? acc[31:24] : ALPHA_OPAQUE;
      r.repeat_count = count[7:0];
      r.dest_row = row;
      r.dest_column = col;
      r.image_width = width;
      r.image_height = height;
      total = col + count;
      adv = total / width;
      col = 16'(total % width);
      done = (adv >= rows_left);
      if (done) begin
        rows_left = '0;
      end else begin
        rows_left = 16'(rows_left - adv);
        row = top ? 16'(row + adv) : 16'(row - adv);
      end
      r.image_done = done;
      acc = '0;
      byte_idx = '0;
      return done;
    endfunction

    function void decode_byte(logic [7:0] b, logic last);
      res_t r;
      bit have, hdr_err, done;
      logic [2:0] code;
      int unsigned nbytes, count;
      longint unsigned left;
      have = 0;
      hdr_err = 0;
      r = '0;
      case (phase)
        PH_HEADER: begin
          case (hdr_idx)
            HDR_ID_LEN: id_left = b;
            HDR_CMAP:   cmap = (b != 0);
            HDR_TYPE:   img_type = b;
            HDR_W_LO:   width[7:0] = b;
            HDR_W_HI:   width[15:8] = b;
            HDR_H_LO:   height[7:0] = b;
            HDR_H_HI:   height[15:8] = b;
            HDR_BPP:    depth = b;
            default: ;
          endcase
          if (hdr_idx == HDR_DESC) begin
            top = b[ATTR_TOP_BIT];
            code = ERR_NONE;
            if (img_type != IMG_RGB && img_type != IMG_GRAY && img_type != IMG_RLE)
              code = ERR_BAD_TYPE;
            else if (cmap)
              code = ERR_COLORMAP;
            else if (!(depth == BPP_24 || depth == BPP_32 ||
                       (depth == BPP_8 && img_type == IMG_GRAY)))
              code = ERR_BAD_BPP;
            else if (width == 0 || height == 0)
              code = ERR_EMPTY;
            if (code != ERR_NONE) begin
              r = error_result(code);
              phase = PH_IGNORE;
              hdr_err = 1;
            end else begin
              r.kind = KIND_HEADER;
              r.image_width = width;
              r.image_height = height;
              rows_left = height;
              row = top ? 16'd0 : height - 16'd1;
              col = '0;
              phase = (id_left != 0) ? PH_IDSKIP : data_phase();
            end
            have = 1;
          end else begin
            hdr_idx = hdr_idx + 5'd1;
          end
        end
        PH_IDSKIP: begin
          id_left = id_left - 8'd1;
          if (id_left == 0) phase = data_phase();
        end
        PH_PACKET: begin
          pkt_left = {1'b0, b[6:0]} + 8'd1;
          pkt_run = b[PKT_RUN_BIT];
          acc = '0;
          byte_idx = '0;
          phase = PH_PIXEL;
        end
        PH_PIXEL: begin
          nbytes = 32'(depth >> 3);
          acc = acc | (32'(b) << (8 * byte_idx));
          if (byte_idx + 1 < nbytes) begin
            byte_idx = byte_idx + 2'd1;
          end else begin
            count = 1;
            if (img_type == IMG_RLE) begin
              if (pkt_run) begin
                // a run never reaches past the last pixel of the image
                left = 64'(rows_left);
                left = (left - 1) * width + width - col;
                count = 32'(pkt_left);
                if (count > left) count = 32'(left);
                pkt_left = '0;
              end else begin
                pkt_left = pkt_left - 8'd1;
              end
              done = pixel_run(count, r);
              if (done) phase = PH_IGNORE;
              else if (pkt_left == 0) phase = PH_PACKET;
            end else begin
              done = pixel_run(count, r);
              if (done) phase = PH_IGNORE;
            end
            have = 1;
          end
        end
        default: ;
      endcase
      if (last) begin
        if (phase != PH_IGNORE && !hdr_err) begin
          r = error_result(ERR_TRUNCATED);
          have = 1;
        end
        clear_state();
      end
      if (have) expected_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(res_t got);
      res_t want;
      string diffs;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing pending, kind %0d", got.kind));
        return;
      end
      want = expected_results.pop_front();
      diffs = "";
      if (got.kind !== want.kind) diffs = {diffs, " kind"};
      if (got.red !== want.red) diffs = {diffs, " red"};
      if (got.green !== want.green) diffs = {diffs, " green"};
      if (got.blue !== want.blue) diffs = {diffs, " blue"};
      if (got.alpha !== want.alpha) diffs = {diffs, " alpha"};
      if (got.repeat_count !== want.repeat_count) diffs = {diffs, " repeat_count"};
      if (got.dest_row !== want.dest_row) diffs = {diffs, " dest_row"};
      if (got.dest_column !== want.dest_column) diffs = {diffs, " dest_column"};
      if (got.image_width !== want.image_width) diffs = {diffs, " image_width"};
      if (got.image_height !== want.image_height) diffs = {diffs, " image_height"};
      if (got.error_code !== want.error_code) diffs = {diffs, " error_code"};
      if (got.image_done !== want.image_done) diffs = {diffs, " image_done"};
      if (diffs != "") report($sformatf("bad%s: got %h want %h", diffs, got, want));
    endtask
  endclass

  logic clk, rst_n;
  logic [7:0] in_tdata;
  logic in_tlast, in_tvalid, in_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast, out_tvalid, out_tready;

  decode_tracker tracker;
  int send_idle_pct, recv_stall_pct, bytes_sent;
  bit hold_request;
  logic [7:0] file_q[$];

  tga_image_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // sink side, with a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = 300;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser);
      got.red = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue = out_tdata[23:16];
      got.alpha = out_tdata[31:24];
      got.repeat_count = out_tdata[39:32];
      got.dest_row = out_tdata[55:40];
      got.dest_column = out_tdata[71:56];
      got.image_width = out_tdata[87:72];
      got.image_height = out_tdata[103:88];
      got.error_code = out_tdata[106:104];
      got.image_done = out_tlast;
      tracker.check_result(got);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.decode_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  function automatic void add_header(int id_len, int cmap, logic [7:0] img, int w, int h,
                                     logic [7:0] depth, logic [7:0] desc);
    file_q.push_back(id_len[7:0]);
    file_q.push_back(cmap[7:0]);
    file_q.push_back(img);
    repeat (9) file_q.push_back(8'($urandom_range(255)));
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(depth);
    file_q.push_back(desc);
    repeat (id_len) file_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_pixel(logic [7:0] depth);
    repeat (depth >> 3) file_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_image(logic [7:0] img, logic [7:0] depth, int npix);
    int rem, cnt;
    bit run;
    if (img != IMG_RLE) begin
      repeat (npix) add_pixel(depth);
      return;
    end
    rem = npix;
    while (rem > 0) begin
      run = 1'($urandom_range(1));
      if ((run && $urandom_range(3) == 0) || $urandom_range(15) == 0)
        cnt = $urandom_range(128, 1);
      else
        cnt = $urandom_range((rem < 6) ? rem : 6, 1);
      file_q.push_back({run, 7'(cnt - 1)});
      if (run) add_pixel(depth);
      else repeat (cnt) add_pixel(depth);
      rem -= cnt;
    end
  endfunction

  function automatic bit depth_ok(logic [7:0] img, logic [7:0] depth);
    return depth == BPP_24 || depth == BPP_32 || (depth == BPP_8 && img == IMG_GRAY);
  endfunction

  function automatic void make_random_file();
    int sel, w, h, id_len, npix, cut, cmap;
    logic [7:0] img, depth;
    file_q.delete();
    sel = $urandom_range(99);
    id_len = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
    if ($urandom_range(99) == 0) id_len = 255;
    case ($urandom_range(2))
      0: img = IMG_RGB;
      1: img = IMG_GRAY;
      default: img = IMG_RLE;
    endcase
    depth = $urandom_range(1) ? BPP_24 : BPP_32;
    if (img == IMG_GRAY && $urandom_range(2) == 0) depth = BPP_8;
    w = $urandom_range(4, 1);
    h = $urandom_range(3, 1);
    cmap = 0;
    if (sel < 75) begin
      // well-formed image, now and then huge and cut short
      if ($urandom_range(15) == 0) begin
        w = $urandom_range(65535, 1);
        h = $urandom_range(65535, 1);
        npix = $urandom_range(24, 1);
      end else begin
        npix = w * h;
      end
      add_header(id_len, 0, img, w, h, depth, 8'($urandom_range(255)));
      add_image(img, depth, npix);
      if ($urandom_range(4) == 0) begin
        cut = $urandom_range(file_q.size() - 1, 1);
        while (file_q.size() > cut) void'(file_q.pop_back());
      end else begin
        repeat ($urandom_range(2)) file_q.push_back(8'($urandom_range(255)));
      end
    end else if (sel < 90) begin
      // header that must be refused
      w = $urandom_range(65535, 1);
      h = $urandom_range(65535, 1);
      case ($urandom_range(3))
        0: begin
          do img = 8'($urandom_range(255));
          while (img == IMG_RGB || img == IMG_GRAY || img == IMG_RLE);
        end
        1: cmap = $urandom_range(255, 1);
        2: begin
          do depth = 8'($urandom_range(255));
          while (depth_ok(img, depth));
        end
        default: begin
          case ($urandom_range(2))
            0: w = 0;
            1: h = 0;
            default: begin
              w = 0;
              h = 0;
            end
          endcase
        end
      endcase
      add_header(id_len, cmap, img, w, h, depth, 8'($urandom_range(255)));
      repeat ($urandom_range(3)) file_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(30, 1)) file_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic run_directed();
    // gray bottom-up, last pixel on the final byte
    file_q.delete();
    add_header(0, 0, IMG_GRAY, 2, 2, BPP_8, 8'h00);
    file_q.push_back(8'h00);
    file_q.push_back(8'hff);
    file_q.push_back(8'h55);
    file_q.push_back(8'haa);
    send_file();
    // top-down rgb after an id field
    file_q.delete();
    add_header(2, 0, IMG_RGB, 1, 1, BPP_24, 8'h20);
    add_pixel(BPP_24);
    send_file();
    // rgba with trailing bytes
    file_q.delete();
    add_header(0, 0, IMG_RGB, 2, 1, BPP_32, 8'h28);
    repeat (4) file_q.push_back(8'hff);
    repeat (4) file_q.push_back(8'h00);
    file_q.push_back(8'h5a);
    file_q.push_back(8'ha5);
    send_file();
    // run longer than the image gets cut
    file_q.delete();
    add_header(0, 0, IMG_RLE, 3, 2, BPP_24, 8'h00);
    file_q.push_back(8'hff);
    add_pixel(BPP_24);
    send_file();
    // full 128 pixel run
    file_q.delete();
    add_header(0, 0, IMG_RLE, 128, 1, BPP_32, 8'h20);
    file_q.push_back(8'hff);
    add_pixel(BPP_32);
    send_file();
    // raw packet then a run wrapping rows
    file_q.delete();
    add_header(0, 0, IMG_RLE, 3, 2, BPP_32, 8'h00);
    file_q.push_back(8'h01);
    add_pixel(BPP_32);
    add_pixel(BPP_32);
    file_q.push_back(8'h83);
    add_pixel(BPP_32);
    send_file();
    // header errors, the first ending on the descriptor byte
    file_q.delete();
    add_header(0, 0, 8'd1, 4, 4, BPP_24, 8'h00);
    send_file();
    file_q.delete();
    add_header(0, 1, IMG_RGB, 4, 4, BPP_24, 8'h00);
    file_q.push_back(8'h00);
    send_file();
    file_q.delete();
    add_header(0, 0, IMG_RGB, 4, 4, BPP_8, 8'h00);
    file_q.push_back(8'h00);
    send_file();
    file_q.delete();
    add_header(0, 0, IMG_RLE, 4, 4, 8'd16, 8'h00);
    file_q.push_back(8'h00);
    send_file();
    file_q.delete();
    add_header(0, 0, IMG_RGB, 0, 0, BPP_24, 8'h00);
    file_q.push_back(8'h00);
    send_file();
    // truncation: one byte, on the descriptor, in the id field, in pixels
    file_q.delete();
    file_q.push_back(8'h00);
    send_file();
    file_q.delete();
    add_header(0, 0, IMG_RGB, 1, 1, BPP_24, 8'h00);
    send_file();
    file_q.delete();
    add_header(3, 0, IMG_RGB, 1, 1, BPP_24, 8'h00);
    void'(file_q.pop_back());
    send_file();
    file_q.delete();
    add_header(0, 0, IMG_RLE, 65535, 65535, BPP_32, 8'h20);
    file_q.push_back(8'h80);
    repeat (4) file_q.push_back(8'hff);
    file_q.push_back(8'h7f);
    repeat (8) file_q.push_back(8'h00);
    send_file();
  endtask

  initial begin
    int phase_start;
    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    bytes_sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_request = 1;
        end
        1: begin
          send_idle_pct = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 375) begin
        make_random_file();
        send_file();
      end
    end
    in_tvalid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
